// ===== hw/rtl/can_tx_ring_queue_mailbox_unit_assert.svh =====
// ----------------------------------------------------------------------------
// CAN transmit queue assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CAN_TX_RING_QUEUE_MAILBOX_UNIT_ASSERT_SVH
`define CAN_TX_RING_QUEUE_MAILBOX_UNIT_ASSERT_SVH

// Same-cycle implication
`define CTXQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctxq assertion failed");

// Next-cycle implication
`define CTXQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctxq assertion failed");

`endif

// ===== hw/rtl/ctxq_pkg.sv =====
// ----------------------------------------------------------------------------
// ctxq_pkg
// Types, constants and ring helpers for the CAN transmit queue.
// ----------------------------------------------------------------------------
package ctxq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = 6;
  localparam int unsigned ID_SHIFT    = 21;
  localparam logic [31:0] REQUEST_BIT = 32'h0000_0001;

  // Request codes on req_type
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_MB_FREE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_SEND,
    OP_CLEAR,
    OP_NOP
  } ctxq_op_e;

  // Classified request handed from front to back
  typedef struct packed {
    ctxq_op_e    op;
    logic        mailbox_free;
    logic [10:0] msg_id;
    logic [3:0]  msg_length;
    logic [31:0] data_high;
    logic [31:0] data_low;
  } ctxq_cmd_t;

  // One ring entry as stored in RAM
  typedef struct packed {
    logic [10:0] msg_id;
    logic [3:0]  msg_length;
    logic [31:0] data_high;
    logic [31:0] data_low;
  } ctxq_entry_t;

  localparam int unsigned ENTRY_W = $bits(ctxq_entry_t);

  // Result bundle from back to top level
  typedef struct packed {
    logic              done;
    logic              accepted;
    logic              sent;
    logic [31:0]       id_word;
    logic [3:0]        dlc;
    logic [31:0]       data_low;
    logic [31:0]       data_high;
    logic [QCNT_W-1:0] count;
  } ctxq_result_t;

  // Next ring position
  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // Occupancy from tail and head
  function automatic ptr_t ring_cnt(ptr_t t, ptr_t h);
    logic [PTR_W:0] s;
    s = {1'b0, t} + (PTR_W + 1)'(QUEUE_DEPTH) - {1'b0, h};
    if (s >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (PTR_W + 1)'(QUEUE_DEPTH);
    end
    return ptr_t'(s);
  endfunction

endpackage

// ===== hw/rtl/ctxq_ram.sv =====
// ----------------------------------------------------------------------------
// ctxq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctxq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ctxq_front.sv =====
// ----------------------------------------------------------------------------
// ctxq_front
// Takes requests, decodes req_type and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ctxq_front import ctxq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic        mailbox_free_i,
  input  logic [10:0] msg_id_i,
  input  logic [3:0]  msg_length_i,
  input  logic [31:0] data_word_low_i,
  input  logic [31:0] data_word_high_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output ctxq_cmd_t   cmd_o
);

  ctxq_cmd_t  store_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  ctxq_cmd_t  cmd_in;

  // Decode the request code
  always_comb begin
    cmd_in.mailbox_free = mailbox_free_i;
    cmd_in.msg_id       = msg_id_i;
    cmd_in.msg_length   = msg_length_i;
    cmd_in.data_high    = data_word_high_i;
    cmd_in.data_low     = data_word_low_i;
    unique case (req_type_i)
      REQ_ENQUEUE: cmd_in.op = OP_PUSH;
      REQ_MB_FREE: cmd_in.op = OP_SEND;
      REQ_CLEAR:   cmd_in.op = OP_CLEAR;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  assign busy        = (fill_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = store_q[rd_ptr_q];

  // Pointer and fill update
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/ctxq_back.sv =====
// ----------------------------------------------------------------------------
// ctxq_back
// Runs queued requests against the frame ring and builds mailbox results.
// ----------------------------------------------------------------------------
`include "can_tx_ring_queue_mailbox_unit_assert.svh"

module ctxq_back import ctxq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  ctxq_cmd_t    cmd_i,
  output ctxq_result_t result_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DATA
  } state_e;

  state_e       state_q, state_d;
  ptr_t         head_q, head_d;
  ptr_t         tail_q, tail_d;
  logic         pend_acc_q, pend_acc_d;
  ctxq_result_t res_q, res_d;

  logic                 ram_we;
  logic                 ram_re;
  ctxq_entry_t          wr_entry;
  logic [ENTRY_W-1:0]   ram_rdata;
  ctxq_entry_t          rd_entry;
  ptr_t                 cnt_now;
  logic                 emit;

  assign cnt_now  = ring_cnt(tail_q, head_q);
  assign rd_entry = ctxq_entry_t'(ram_rdata);

  always_comb begin
    wr_entry.msg_id     = cmd_i.msg_id;
    wr_entry.msg_length = cmd_i.msg_length;
    wr_entry.data_high  = cmd_i.data_high;
    wr_entry.data_low   = cmd_i.data_low;
  end

  // Frame ring storage
  ctxq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer and result build
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    pend_acc_d  = pend_acc_q;
    res_d       = '0;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    emit        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.op)
            OP_PUSH: begin
              if (cnt_now == ptr_t'(QUEUE_DEPTH - 1)) begin
                emit = 1'b1;
              end else begin
                ram_we = 1'b1;
                tail_d = ptr_inc(tail_q);
                if (cmd_i.mailbox_free) begin
                  pend_acc_d = 1'b1;
                  state_d    = S_READ;
                end else begin
                  res_d.accepted = 1'b1;
                  emit           = 1'b1;
                end
              end
            end
            OP_SEND: begin
              if (cnt_now != '0 && cmd_i.mailbox_free) begin
                ram_re     = 1'b1;
                pend_acc_d = 1'b0;
                state_d    = S_DATA;
              end else begin
                emit = 1'b1;
              end
            end
            OP_CLEAR: begin
              head_d = '0;
              tail_d = '0;
              emit   = 1'b1;
            end
            OP_NOP: begin
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // entry written last cycle, now read at head
        ram_re  = 1'b1;
        state_d = S_DATA;
      end
      S_DATA: begin
        emit            = 1'b1;
        res_d.accepted  = pend_acc_q;
        res_d.sent      = 1'b1;
        res_d.id_word   = (32'(rd_entry.msg_id) << ID_SHIFT) | REQUEST_BIT;
        res_d.dlc       = rd_entry.msg_length;
        res_d.data_low  = rd_entry.data_low;
        res_d.data_high = rd_entry.data_high;
        head_d          = ptr_inc(head_q);
        pend_acc_d      = 1'b0;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.done  = emit;
    res_d.count = QCNT_W'(ring_cnt(tail_d, head_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      pend_acc_q <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      pend_acc_q <= pend_acc_d;
      res_q      <= res_d;
    end
  end

  assign result_o = res_q;

  // Checks
  `CTXQ_ASSERT(a_read_not_empty, ram_re, cnt_now != '0)
  `CTXQ_ASSERT(a_no_write_when_full, ram_we, cnt_now != ptr_t'(QUEUE_DEPTH - 1))
  `CTXQ_ASSERT_NEXT(a_data_gives_send, state_q == S_DATA, res_q.done && res_q.sent)
  `CTXQ_ASSERT(a_send_pops_head, res_q.done && res_q.sent, head_q == ptr_inc($past(head_q)))

endmodule

// ===== hw/rtl/can_tx_ring_queue_mailbox_unit.sv =====
// ----------------------------------------------------------------------------
// can_tx_ring_queue_mailbox_unit
// Transmit queue of standard CAN frames feeding transmit mailbox zero.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. It
//   carries req_type (enqueue, mailbox empty, clear), mailbox_free and, for
//   an enqueue, the frame id, length code and two data words.
//   Every request gives exactly one result, shown for one cycle with done_o
//   high; the receiver has no way to stall it.
//   A request passes the request queue and the registered result; a
//   sending mailbox-empty event adds the registered ring RAM read, a sending
//   enqueue adds the ring RAM write and then its registered read. Requests
//   that send nothing run at one per cycle; a sending request holds the
//   executor in its read and data states, with a two-entry request queue
//   in front taking further requests until it fills.
//   The ring RAM has QUEUE_DEPTH entries; the ring is full at QUEUE_DEPTH-1.
//   Reset empties the ring and the request queue; ring RAM contents are
//   left as they are and are only read after being written.
// ----------------------------------------------------------------------------
module can_tx_ring_queue_mailbox_unit import ctxq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type_i,
  input  logic              mailbox_free_i,
  input  logic [10:0]       msg_id_i,
  input  logic [3:0]        msg_length_i,
  input  logic [31:0]       data_word_low_i,
  input  logic [31:0]       data_word_high_i,
  output logic              done_o,
  output logic              accepted_o,
  output logic              sent_o,
  output logic [31:0]       mailbox_id_word_o,
  output logic [3:0]        mailbox_dlc_o,
  output logic [31:0]       mailbox_data_low_o,
  output logic [31:0]       mailbox_data_high_o,
  output logic [QCNT_W-1:0] queue_count_o
);

  logic         cmd_valid;
  logic         cmd_ready;
  ctxq_cmd_t    cmd;
  ctxq_result_t result;

  // Request intake and decode
  ctxq_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .mailbox_free_i   (mailbox_free_i),
    .msg_id_i         (msg_id_i),
    .msg_length_i     (msg_length_i),
    .data_word_low_i  (data_word_low_i),
    .data_word_high_i (data_word_high_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready),
    .cmd_o            (cmd)
  );

  // Ring and mailbox executor
  ctxq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .result_o    (result)
  );

  assign done_o              = result.done;
  assign accepted_o          = result.accepted;
  assign sent_o              = result.sent;
  assign mailbox_id_word_o   = result.id_word;
  assign mailbox_dlc_o       = result.dlc;
  assign mailbox_data_low_o  = result.data_low;
  assign mailbox_data_high_o = result.data_high;
  assign queue_count_o       = result.count;

endmodule
